FILE: rtl/pird_pkg.sv
// Shared types, widths, constants and register indexes of the beat rate display core.
package pird_pkg;

    localparam int TICKS_W  = 16;
    localparam int FACTOR_W = 24;
    localparam int QUOT_W   = 24;
    localparam int LIMIT_W  = 8;
    localparam int PROD_W   = LIMIT_W + TICKS_W;
    localparam int RATE_W   = 16;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    localparam int DIV_BITS = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT  = 2'd2;

    localparam logic [FACTOR_W-1:0] RESET_RATE_FACTOR = 24'd1875000;
    localparam logic [LIMIT_W-1:0]  RESET_LOW_LIMIT   = 8'd40;
    localparam logic [LIMIT_W-1:0]  RESET_HIGH_LIMIT  = 8'd180;

    localparam logic [RATE_W-1:0] RATE_SAT    = 16'hFFFF;
    localparam logic [QUOT_W-1:0] DISPLAY_MAX = 24'd999;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] ASCII_E     = 8'h45;
    localparam logic [CHAR_W-1:0] ASCII_R     = 8'h52;

    // floor(v / 100) = (v * 41) >> 12 for v < 1000
    localparam logic [15:0] HUND_RECIP = 16'd41;
    localparam int          HUND_SHIFT = 12;
    localparam logic [9:0]  HUND_VAL   = 10'd100;
    // floor(r / 10) = (r * 205) >> 11 for r < 100
    localparam logic [14:0] TEN_RECIP  = 15'd205;
    localparam int          TEN_SHIFT  = 11;
    localparam logic [6:0]  TEN_VAL    = 7'd10;

    typedef struct packed {
        logic [TICKS_W-1:0] rem;
        logic [QUOT_W-1:0]  nq;
        logic [TICKS_W-1:0] den;
        logic               zero;
        logic               oor;
    } t_div_s;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [CHAR_W-1:0] ch_hund;
        logic [CHAR_W-1:0] ch_tens;
        logic [CHAR_W-1:0] ch_ones;
        logic              oor;
        logic              err;
    } t_res_s;

endpackage

FILE: rtl/pird_div_stage.sv
// One stage of the pipelined restoring divider, P_STEP_BITS quotient bits per stage.
module pird_div_stage #(
    parameter int P_STEP_BITS = pird_pkg::DIV_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pird_pkg::t_div_s  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output pird_pkg::t_div_s  o_data
);

    logic             r_valid;
    pird_pkg::t_div_s r_data;
    pird_pkg::t_div_s n_data;

    always_comb begin
        logic [pird_pkg::TICKS_W:0] v_trial;
        logic [pird_pkg::TICKS_W:0] v_diff;
        pird_pkg::t_div_s           v_d;
        v_d = i_data;
        for (int k = 0; k < P_STEP_BITS; k++) begin
            v_trial = {v_d.rem, v_d.nq[pird_pkg::QUOT_W-1]};
            v_diff  = v_trial - {1'b0, v_d.den};
            v_d.nq  = {v_d.nq[pird_pkg::QUOT_W-2:0], 1'b0};
            if (v_trial >= {1'b0, v_d.den}) begin
                v_d.rem   = v_diff[pird_pkg::TICKS_W-1:0];
                v_d.nq[0] = 1'b1;
            end else begin
                v_d.rem = v_trial[pird_pkg::TICKS_W-1:0];
            end
        end
        n_data = v_d;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: rtl/pird_digits.sv
// Saturation, error test and two-stage decimal split into display characters.
module pird_digits (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pird_pkg::t_div_s  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output pird_pkg::t_res_s  o_data
);

    logic                           r_x_valid;
    logic [pird_pkg::RATE_W-1:0]    r_x_rate;
    logic                           r_x_err;
    logic                           r_x_oor;
    logic [pird_pkg::DIGIT_W-1:0]   r_x_hund;
    logic [6:0]                     r_x_rest;
    logic                           r_y_valid;
    pird_pkg::t_res_s               r_y_data;

    logic [pird_pkg::QUOT_W-1:0]    w_quot;
    logic [9:0]                     w_q10;
    logic [15:0]                    w_h_prod;
    logic [pird_pkg::DIGIT_W-1:0]   w_hund;
    logic [9:0]                     w_rest10;
    logic [pird_pkg::RATE_W-1:0]    n_x_rate;
    logic                           n_x_err;
    logic [14:0]                    w_t_prod;
    logic [pird_pkg::DIGIT_W-1:0]   w_tens;
    logic [6:0]                     w_ones7;
    logic [pird_pkg::DIGIT_W-1:0]   w_ones;
    pird_pkg::t_res_s               n_y_data;
    logic                           w_x_ready;
    logic                           w_y_ready;

    assign w_quot   = i_data.nq;
    assign w_q10    = w_quot[9:0];
    assign w_h_prod = {6'd0, w_q10} * pird_pkg::HUND_RECIP;
    assign w_hund   = w_h_prod[pird_pkg::HUND_SHIFT +: pird_pkg::DIGIT_W];
    assign w_rest10 = w_q10 - ({6'd0, w_hund} * pird_pkg::HUND_VAL);
    assign n_x_rate = i_data.zero ? '0 :
                      (w_quot > {8'd0, pird_pkg::RATE_SAT}) ? pird_pkg::RATE_SAT :
                      w_quot[pird_pkg::RATE_W-1:0];
    assign n_x_err  = i_data.zero || (w_quot > pird_pkg::DISPLAY_MAX);

    assign w_t_prod = {8'd0, r_x_rest} * pird_pkg::TEN_RECIP;
    assign w_tens   = w_t_prod[pird_pkg::TEN_SHIFT +: pird_pkg::DIGIT_W];
    assign w_ones7  = r_x_rest - ({3'd0, w_tens} * pird_pkg::TEN_VAL);
    assign w_ones   = w_ones7[pird_pkg::DIGIT_W-1:0];

    always_comb begin
        n_y_data.rate = r_x_rate;
        n_y_data.oor  = r_x_oor;
        n_y_data.err  = r_x_err;
        if (r_x_err) begin
            n_y_data.ch_hund = pird_pkg::ASCII_E;
            n_y_data.ch_tens = pird_pkg::ASCII_R;
            n_y_data.ch_ones = pird_pkg::ASCII_R;
        end else begin
            n_y_data.ch_hund = (r_x_hund == '0) ? pird_pkg::ASCII_SPACE :
                               (pird_pkg::ASCII_ZERO | {4'd0, r_x_hund});
            n_y_data.ch_tens = (r_x_hund == '0 && w_tens == '0) ? pird_pkg::ASCII_SPACE :
                               (pird_pkg::ASCII_ZERO | {4'd0, w_tens});
            n_y_data.ch_ones = pird_pkg::ASCII_ZERO | {4'd0, w_ones};
        end
    end

    assign w_y_ready = !r_y_valid || i_ready;
    assign w_x_ready = !r_x_valid || w_y_ready;
    assign o_ready   = w_x_ready;
    assign o_valid   = r_y_valid;
    assign o_data    = r_y_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
            r_y_valid <= 1'b0;
        end else begin
            if (w_x_ready) begin
                r_x_valid <= i_valid;
            end
            if (w_y_ready) begin
                r_y_valid <= r_x_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_x_ready && i_valid) begin
            r_x_rate <= n_x_rate;
            r_x_err  <= n_x_err;
            r_x_oor  <= i_data.oor;
            r_x_hund <= w_hund;
            r_x_rest <= w_rest10[6:0];
        end
        if (w_y_ready && r_x_valid) begin
            r_y_data <= n_y_data;
        end
    end

endmodule

FILE: rtl/pulse_interval_to_rate_display_core.sv
// Top level of the beat interval to rate display core: config, limit test, divider, digits.
//
// channel   direction  handshake                  payload
// s_axis    in         tvalid/tready              tdata[15:0] interval_ticks
// m_axis    out        tvalid/tready              tdata: rate, three chars, oor, err
// cfg       in         we (no wait, no read-back) addr 0 factor, 1 low, 2 high limit
//
// One request per cycle while the output is not stalled; each request passes through the
// A and B registers, the pipelined restoring divider stages and the digit registers X and Y.
// Reset clears all stage valid bits and loads the configuration reset values.
// Each stage holds its request while the stage after it is full and stalled.
module pulse_interval_to_rate_display_core #(
    parameter int P_DIV_BITS = pird_pkg::DIV_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] interval_ticks
    input  logic [pird_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] rate_bpm, [23:16] char_hundreds, [31:24] char_tens, [39:32] char_ones,
    // [40] out_of_range, [41] reading_error, [47:42] zero
    output logic [pird_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [pird_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [pird_pkg::FACTOR_W-1:0]       i_cfg_wdata
);

    localparam int DIV_STAGES = pird_pkg::QUOT_W / P_DIV_BITS;

    logic [pird_pkg::FACTOR_W-1:0] r_factor;
    logic [pird_pkg::LIMIT_W-1:0]  r_low;
    logic [pird_pkg::LIMIT_W-1:0]  r_high;

    logic                          r_a_valid;
    logic [pird_pkg::TICKS_W-1:0]  r_a_ticks;
    logic [pird_pkg::FACTOR_W-1:0] r_a_factor;
    logic [pird_pkg::PROD_W-1:0]   r_a_lo;
    logic [pird_pkg::PROD_W-1:0]   r_a_hi;
    logic                          r_b_valid;
    pird_pkg::t_div_s              r_b_data;
    pird_pkg::t_div_s              n_b_data;

    logic                          w_a_ready;
    logic                          w_b_ready;
    logic                          w_vld [0:DIV_STAGES];
    logic                          w_rdy [0:DIV_STAGES];
    pird_pkg::t_div_s              w_div [0:DIV_STAGES];
    pird_pkg::t_res_s              w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= pird_pkg::RESET_RATE_FACTOR;
            r_low    <= pird_pkg::RESET_LOW_LIMIT;
            r_high   <= pird_pkg::RESET_HIGH_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pird_pkg::CFG_RATE_FACTOR: r_factor <= i_cfg_wdata;
                pird_pkg::CFG_LOW_LIMIT:   r_low    <= i_cfg_wdata[pird_pkg::LIMIT_W-1:0];
                pird_pkg::CFG_HIGH_LIMIT:  r_high   <= i_cfg_wdata[pird_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_b_ready       = !r_b_valid || w_rdy[0];
    assign w_a_ready       = !r_a_valid || w_b_ready;
    assign o_s_axis_tready = w_a_ready;

    always_comb begin
        n_b_data.rem  = '0;
        n_b_data.nq   = r_a_factor;
        n_b_data.den  = r_a_ticks;
        n_b_data.zero = (r_a_ticks == '0);
        n_b_data.oor  = (r_a_ticks == '0) || (r_a_factor < r_a_lo) || (r_a_factor > r_a_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_s_axis_tvalid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_s_axis_tvalid) begin
            r_a_ticks  <= i_s_axis_tdata[pird_pkg::TICKS_W-1:0];
            r_a_factor <= r_factor;
            r_a_lo     <= {{pird_pkg::TICKS_W{1'b0}}, r_low} *
                          {{pird_pkg::LIMIT_W{1'b0}}, i_s_axis_tdata[pird_pkg::TICKS_W-1:0]};
            r_a_hi     <= {{pird_pkg::TICKS_W{1'b0}}, r_high} *
                          {{pird_pkg::LIMIT_W{1'b0}}, i_s_axis_tdata[pird_pkg::TICKS_W-1:0]};
        end
        if (w_b_ready && r_a_valid) begin
            r_b_data <= n_b_data;
        end
    end

    assign w_vld[0] = r_b_valid;
    assign w_div[0] = r_b_data;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        pird_div_stage #(
            .P_STEP_BITS (P_DIV_BITS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_data  (w_div[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_data  (w_div[g+1])
        );
    end

    pird_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vld[DIV_STAGES]),
        .o_ready (w_rdy[DIV_STAGES]),
        .i_data  (w_div[DIV_STAGES]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_res)
    );

    assign o_m_axis_tdata = {6'd0, w_res.err, w_res.oor, w_res.ch_ones, w_res.ch_tens,
                             w_res.ch_hund, w_res.rate};

    a_err_shows_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[41]) |->
        (o_m_axis_tdata[23:16] == pird_pkg::ASCII_E && o_m_axis_tdata[31:24] == pird_pkg::ASCII_R
         && o_m_axis_tdata[39:32] == pird_pkg::ASCII_R))
        else $error("error reading without ERR display");

    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[41]) |-> (o_m_axis_tdata[15:0] <= 16'd999))
        else $error("displayed rate above 999");

    a_zero_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[41] && o_m_axis_tdata[15:0] == '0) |->
        o_m_axis_tdata[40])
        else $error("zero interval without out_of_range");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while output is empty");

endmodule
